// File: hw/rtl/ccbi_pkg.sv
// Package for the chart curve blend interpolator: widths, status codes,
// chart constants and the three Q.12 ROM curves. No dependencies.
package ccbi_pkg;

    localparam int TABLE_POINTS_DEF  = 24;
    localparam int FRACTION_BITS_DEF = 12;
    localparam int ROM_POINTS        = 24;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NEGATIVE = 2'd1,
        ST_ABOVE    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ARG_NONE  = 2'd0,
        ARG_MACH  = 2'd1,
        ARG_ZETA  = 2'd2,
        ARG_SLOPE = 2'd3
    } t_arg;

    // Breakpoint abscissae (Q.12, prescaled by degrees per radian)
    function automatic int rom_x(input int c, input int i);
        int t [24];
        t = '{0, 230, 587, 1173, 1760, 2347, 2934, 3520, 4107, 4694, 5280, 5867,
              6454, 7041, 7627, 8214, 8801, 9387, 9974, 10561, 11147, 11734,
              12321, 12556};
        if (i == 1) begin
            case (c)
                0:       return 230;
                1:       return 256;
                default: return 296;
            endcase
        end
        return t[i];
    endfunction

    // Curve ordinates (Q.12)
    function automatic int rom_y(input int c, input int i);
        int a [24];
        int b [24];
        int d [24];
        a = '{10272, 10859, 11541, 12241, 12610, 12828, 12951, 12970, 12889, 12733,
              12508, 12220, 11870, 11458, 10980, 10426, 9778, 8990, 8064, 6990,
              5672, 3923, 1376, 0};
        b = '{10272, 9405, 8644, 7625, 6808, 6112, 5507, 4981, 4533, 4116,
              3708, 3311, 2929, 2563, 2217, 1891, 1585, 1297, 1028, 773,
              533, 304, 85, 0};
        d = '{10272, 10073, 9878, 9485, 9091, 8698, 8304, 7910, 7515, 7096,
              6645, 6158, 5631, 5090, 4548, 4007, 3466, 2924, 2383, 1841,
              1300, 758, 217, 0};
        case (c)
            0:       return a[i];
            1:       return b[i];
            default: return d[i];
        endcase
    endfunction

    // Rescale a Q.12 value to Q.F (truncating toward zero)
    function automatic longint to_qf(input int v, input int f);
        longint r;
        if (f >= 12) begin
            r = longint'(v) <<< (f - 12);
        end else if (v < 0) begin
            r = -((-longint'(v)) >>> (12 - f));
        end else begin
            r = longint'(v) >>> (12 - f);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/chart_curve_blend_interpolator.sv
// Top level of the chart curve blend interpolator: argument checks,
// segment search, three curve interpolations and two blends in a pipeline.
// Depends on ccbi_pkg.
//
// Usage: one request on the slave stream carries mach, zeta and lift slope
// (signed Q3.F, packed in s_axis_tdata). One result leaves on the master
// stream: value (Q2.F), status and the offending argument number.
// A request passes through every stage register in turn; one request is
// taken every cycle while the output is not stalled. Eleven stages:
// check/clamp, segment select, segment product, reciprocal product,
// correction and add, zeta blend product, zeta blend shift, mach blend
// product, mach reciprocal product, correction/select/saturate, output
// register. Divisions by segment width and mach span are reciprocal
// products followed by an exact correction of one in the next stage.
// All stages advance together when the output register is free or being
// taken; a stall by the receiver freezes every stage, and new requests are
// refused whenever the output holds a result that the receiver is not
// taking. Reset clears the valid bits; payload registers are not reset.
module chart_curve_blend_interpolator #(
    parameter int TABLE_POINTS  = ccbi_pkg::TABLE_POINTS_DEF,
    parameter int FRACTION_BITS = ccbi_pkg::FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] mach, [31:16] zeta, [47:32] lift_slope
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [13:0] value, [15:14] status, [17:16] bad_arg, zero fill
    output logic [23:0] m_axis_tdata
);
    import ccbi_pkg::*;

    localparam int F      = FRACTION_BITS;
    localparam int NP     = TABLE_POINTS;
    localparam int SW     = (NP > 1) ? $clog2(NP) : 1;
    localparam int NST    = 11;
    localparam longint ONE_Q     = longint'(1) << F;
    localparam longint MACH_LOW  = ((longint'(11) << F) + 5) / 10;
    localparam longint MACH_HIGH = longint'(2) << F;
    localparam longint MACH_MAX  = longint'(6) << F;
    localparam longint SLOPE_MAX = ((longint'(3065) << F) + 500) / 1000;
    localparam longint MSPAN     = MACH_HIGH - MACH_LOW;
    // numerator widths of the curve and mach divisions
    localparam int     CNW       = 2 * F + 2;
    localparam int     NW        = 2 * F + 3;
    // reciprocal scales for segment widths and for the mach span
    localparam int     RS        = 32;
    localparam int     MRS       = 2 * F + 4;
    localparam longint MRECIP    = ((longint'(1) << MRS) + MSPAN - 1) / MSPAN;

    // Table point for curve c, point i; past the ROM it repeats the end
    function automatic longint px(input int c, input int i);
        int k;
        k = (i < ROM_POINTS) ? i : ROM_POINTS - 1;
        return to_qf(rom_x(c, k), F);
    endfunction
    function automatic longint py(input int c, input int i);
        int k;
        k = (i < ROM_POINTS) ? i : ROM_POINTS - 1;
        return to_qf(rom_y(c, k), F);
    endfunction

    // Reciprocal of each segment width, rounded up
    logic [RS:0] rc_tab [3][NP];
    for (genvar gc = 0; gc < 3; gc++) begin : g_rc_curve
        for (genvar gi = 0; gi < NP; gi++) begin : g_rc_point
            localparam longint W  = px(gc, gi + 1) - px(gc, gi);
            localparam longint RC = (W > 0)
                ? ((longint'(1) << RS) + W - 1) / ((W > 0) ? W : longint'(1)) : 0;
            assign rc_tab[gc][gi] = (RS+1)'(RC);
        end
    end

    // Stage advance
    logic [NST-1:0] r_vld;
    logic           adv;
    assign adv           = !r_vld[NST-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // Stage 1: check and clamp
    logic signed [15:0] in_m, in_z, in_s;
    assign in_m = s_axis_tdata[15:0];
    assign in_z = s_axis_tdata[31:16];
    assign in_s = s_axis_tdata[47:32];

    logic [1:0]  r1_st, r1_bad;
    logic [15:0] r1_m, r1_z, r1_s;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (in_m < 0) begin
                r1_st <= ST_NEGATIVE; r1_bad <= ARG_MACH;
            end else if (in_z < 0) begin
                r1_st <= ST_NEGATIVE; r1_bad <= ARG_ZETA;
            end else if (in_s < 0) begin
                r1_st <= ST_NEGATIVE; r1_bad <= ARG_SLOPE;
            end else if (longint'(in_z) > ONE_Q) begin
                r1_st <= ST_ABOVE; r1_bad <= ARG_ZETA;
            end else begin
                r1_st <= ST_OK; r1_bad <= ARG_NONE;
            end
            r1_m <= (longint'(in_m) > MACH_MAX) ? 16'(MACH_MAX) : in_m;
            r1_s <= (longint'(in_s) > SLOPE_MAX) ? 16'(SLOPE_MAX) : in_s;
            r1_z <= in_z;
        end
    end

    // Stage 2: pick the segment of each curve (independent compares)
    logic [SW-1:0] sel [3];
    logic [2:0]    flat_lo, flat_hi;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sel[c]     = '0;
            flat_lo[c] = (longint'(r1_s) <= px(c, 0));
            flat_hi[c] = 1'b1;
            for (int i = NP - 2; i >= 0; i--) begin
                if (longint'(r1_s) <= px(c, i + 1)) begin
                    sel[c]     = SW'(i);
                    flat_hi[c] = 1'b0;
                end
            end
        end
    end

    logic [1:0]  r2_st, r2_bad;
    logic [15:0] r2_m, r2_z;
    logic signed [19:0] r2_dx [3];
    logic signed [19:0] r2_y0 [3], r2_dy [3];
    logic [RS:0]        r2_rc [3];
    logic signed [19:0] r2_w  [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_st <= r1_st; r2_bad <= r1_bad; r2_m <= r1_m; r2_z <= r1_z;
            for (int c = 0; c < 3; c++) begin
                if (flat_lo[c]) begin
                    r2_y0[c] <= 20'(py(c, 0)); r2_dy[c] <= '0; r2_dx[c] <= '0;
                    r2_rc[c] <= '0; r2_w[c] <= 20'sd1;
                end else if (flat_hi[c]) begin
                    r2_y0[c] <= 20'(py(c, NP - 1)); r2_dy[c] <= '0; r2_dx[c] <= '0;
                    r2_rc[c] <= '0; r2_w[c] <= 20'sd1;
                end else begin
                    r2_y0[c] <= 20'(py(c, int'(sel[c])));
                    r2_dy[c] <= 20'(py(c, int'(sel[c]) + 1) - py(c, int'(sel[c])));
                    r2_dx[c] <= 20'(longint'(r1_s) - px(c, int'(sel[c])));
                    r2_w[c]  <= 20'(px(c, int'(sel[c]) + 1) - px(c, int'(sel[c])));
                    r2_rc[c] <= rc_tab[c][sel[c]];
                end
            end
        end
    end

    // Stage 3: segment product magnitude, rounding numerator
    logic [1:0]  r3_st, r3_bad;
    logic [15:0] r3_m, r3_z;
    logic signed [19:0] r3_y0 [3], r3_w [3];
    logic [CNW-1:0]     r3_n  [3];
    logic [2:0]         r3_ng;
    logic [RS:0]        r3_rc [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_st <= r2_st; r3_bad <= r2_bad; r3_m <= r2_m; r3_z <= r2_z;
            for (int c = 0; c < 3; c++) begin
                logic [19:0] ady;
                ady = (r2_dy[c] < 0) ? 20'(-r2_dy[c]) : 20'(r2_dy[c]);
                r3_ng[c] <= r2_dy[c] < 0;
                r3_n[c]  <= CNW'(ady) * CNW'(r2_dx[c]) + CNW'(r2_w[c] >>> 1);
                r3_y0[c] <= r2_y0[c];
                r3_w[c]  <= r2_w[c];
                r3_rc[c] <= r2_rc[c];
            end
        end
    end

    // Stage 4: quotient estimate by reciprocal product
    logic [1:0]  r4_st, r4_bad;
    logic [15:0] r4_m, r4_z;
    logic signed [19:0] r4_y0 [3], r4_w [3];
    logic [CNW-1:0]     r4_n  [3], r4_q [3];
    logic [2:0]         r4_ng;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_st <= r3_st; r4_bad <= r3_bad; r4_m <= r3_m; r4_z <= r3_z;
            for (int c = 0; c < 3; c++) begin
                logic [CNW+RS:0] pr;
                pr = (CNW+RS+1)'(r3_n[c]) * (CNW+RS+1)'(r3_rc[c]);
                r4_q[c]  <= CNW'(pr >> RS);
                r4_n[c]  <= r3_n[c];
                r4_ng[c] <= r3_ng[c];
                r4_y0[c] <= r3_y0[c];
                r4_w[c]  <= r3_w[c];
            end
        end
    end

    // Stage 5: correct the estimate by one and add to the segment start
    logic [1:0]  r5_st, r5_bad;
    logic [15:0] r5_m, r5_z;
    logic signed [19:0] r5_y [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_st <= r4_st; r5_bad <= r4_bad; r5_m <= r4_m; r5_z <= r4_z;
            for (int c = 0; c < 3; c++) begin
                logic [CNW-1:0] q;
                q = r4_q[c];
                if ((CNW+20)'(q) * (CNW+20)'(r4_w[c]) > (CNW+20)'(r4_n[c])) begin
                    q = q - CNW'(1);
                end
                r5_y[c] <= r4_ng[c] ? 20'(r4_y0[c] - $signed(20'(q)))
                                    : 20'(r4_y0[c] + $signed(20'(q)));
            end
        end
    end

    // Stage 6: zeta blend product of curves B and C
    logic [1:0]  r6_st, r6_bad;
    logic [15:0] r6_m;
    logic signed [19:0] r6_ya, r6_yb0;
    logic [39:0] r6_n;
    logic        r6_ng;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            logic signed [20:0] d;
            logic [20:0] ad;
            d  = 21'(r5_y[2]) - 21'(r5_y[1]);
            ad = (d < 0) ? 21'(-d) : 21'(d);
            r6_st <= r5_st; r6_bad <= r5_bad; r6_m <= r5_m;
            r6_ya  <= r5_y[0];
            r6_yb0 <= r5_y[1];
            r6_ng  <= d < 0;
            r6_n   <= 40'(ad) * 40'(r5_z) + 40'(ONE_Q >> 1);
        end
    end

    // Stage 7: divide by one (shift) and finish the zeta blend
    logic [1:0]  r7_st, r7_bad;
    logic signed [19:0] r7_ya, r7_yb;
    logic [15:0] r7_m;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            logic signed [20:0] q;
            q = $signed(21'(r6_n >> F));
            r7_st <= r6_st; r7_bad <= r6_bad; r7_m <= r6_m; r7_ya <= r6_ya;
            r7_yb <= r6_ng ? 20'(r6_yb0 - q) : 20'(r6_yb0 + q);
        end
    end

    // Stage 8: mach blend numerator and region flags
    logic [1:0]  r8_st, r8_bad;
    logic signed [19:0] r8_ya, r8_yb;
    logic [NW-1:0] r8_n;
    logic        r8_ng, r8_lo, r8_mid;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            logic signed [21:0] d;
            logic [21:0] ad;
            d  = 22'(r7_yb) - 22'(r7_ya);
            ad = (d < 0) ? 22'(-d) : 22'(d);
            r8_st <= r7_st; r8_bad <= r7_bad; r8_ya <= r7_ya; r8_yb <= r7_yb;
            r8_ng  <= d < 0;
            r8_lo  <= longint'(r7_m) < MACH_LOW;
            r8_mid <= longint'(r7_m) < MACH_HIGH;
            r8_n   <= NW'(ad) * NW'(longint'(r7_m) - MACH_LOW) + NW'(MSPAN >> 1);
        end
    end

    // Stage 9: mach quotient estimate by reciprocal product
    logic [1:0]  r9_st, r9_bad;
    logic signed [19:0] r9_ya, r9_yb;
    logic [NW-1:0] r9_n, r9_q;
    logic        r9_ng, r9_lo, r9_mid;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            logic [NW+MRS:0] pr;
            pr = (NW+MRS+1)'(r8_n) * (NW+MRS+1)'(MRECIP);
            r9_q  <= NW'(pr >> MRS);
            r9_n  <= r8_n;
            r9_st <= r8_st; r9_bad <= r8_bad; r9_ya <= r8_ya; r9_yb <= r8_yb;
            r9_ng <= r8_ng; r9_lo <= r8_lo; r9_mid <= r8_mid;
        end
    end

    // Stage 10: correct the mach quotient, select the region and saturate
    logic [1:0]  r10_st, r10_bad;
    logic [13:0] r10_v;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            logic signed [21:0] y;
            logic [NW-1:0] q;
            q = r9_q;
            if ((2*NW)'(q) * (2*NW)'(MSPAN) > (2*NW)'(r9_n)) q = q - NW'(1);
            if (r9_lo)       y = 22'(r9_ya);
            else if (r9_mid) y = r9_ng ? 22'(r9_ya) - $signed(22'(q))
                                       : 22'(r9_ya) + $signed(22'(q));
            else             y = 22'(r9_yb);
            r10_st <= r9_st; r10_bad <= r9_bad;
            if (r9_st != ST_OK || y < 0) r10_v <= '0;
            else if (y > 22'sd16383)     r10_v <= 14'h3FFF;
            else                         r10_v <= 14'(y);
        end
    end

    // Stage 11: output register
    logic [23:0] r11_d;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r11_d <= {6'd0, r10_bad, r10_st, r10_v};
        end
    end
    assign m_axis_tdata = r11_d;

endmodule

// File: dv/ccbi_checker.sv
// Checker for the chart curve blend interpolator: watches both streams,
// predicts each result from the request and compares. Depends on ccbi_pkg.
`timescale 1ns / 100ps

module ccbi_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [47:0] i_req_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [23:0] i_res_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_seen
);
    import ccbi_pkg::*;

    localparam int F = 12;
    localparam longint ONE_Q     = longint'(1) << F;
    localparam longint MACH_LOW  = ((longint'(11) << F) + 5) / 10;
    localparam longint MACH_HIGH = longint'(2) << F;
    localparam longint MACH_MAX  = longint'(6) << F;
    localparam longint SLOPE_MAX = ((longint'(3065) << F) + 500) / 1000;

    // Packed from the top bit down: bad_arg, status, value
    typedef struct packed {
        t_arg        bad_arg;
        t_status     status;
        logic [13:0] value;
    } t_chart_res;

    t_chart_res chart_q[$];

    // Breakpoint tables, Q.12
    int cx [3][24];
    int cy [3][24];

    initial begin
        cx[0] = '{0, 230, 587, 1173, 1760, 2347, 2934, 3520, 4107, 4694, 5280, 5867,
                  6454, 7041, 7627, 8214, 8801, 9387, 9974, 10561, 11147, 11734,
                  12321, 12556};
        cx[1] = cx[0];
        cx[2] = cx[0];
        cx[1][1] = 256;
        cx[2][1] = 296;
        cy[0] = '{10272, 10859, 11541, 12241, 12610, 12828, 12951, 12970, 12889,
                  12733, 12508, 12220, 11870, 11458, 10980, 10426, 9778, 8990, 8064,
                  6990, 5672, 3923, 1376, 0};
        cy[1] = '{10272, 9405, 8644, 7625, 6808, 6112, 5507, 4981, 4533, 4116,
                  3708, 3311, 2929, 2563, 2217, 1891, 1585, 1297, 1028, 773,
                  533, 304, 85, 0};
        cy[2] = '{10272, 10073, 9878, 9485, 9091, 8698, 8304, 7910, 7515, 7096,
                  6645, 6158, 5631, 5090, 4548, 4007, 3466, 2924, 2383, 1841,
                  1300, 758, 217, 0};
    end

    // Divide rounding to nearest, ties away from zero
    function automatic longint div_round(longint n, longint d);
        if (d <= 0) return 0;
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint blend(longint x0, longint y0, longint x1, longint y1,
                                     longint x);
        if (x1 <= x0) return y0;
        return y0 + div_round((y1 - y0) * (x - x0), x1 - x0);
    endfunction

    function automatic longint curve_at(int c, longint x);
        if (x <= cx[c][0]) return cy[c][0];
        for (int i = 0; i < 23; i++)
            if (x <= cx[c][i + 1])
                return blend(cx[c][i], cy[c][i], cx[c][i + 1], cy[c][i + 1], x);
        return cy[c][23];
    endfunction

    function automatic t_chart_res chart_predict(logic [47:0] d);
        t_chart_res r;
        longint m, z, s, ya, yb, y;
        m = longint'($signed(d[15:0]));
        z = longint'($signed(d[31:16]));
        s = longint'($signed(d[47:32]));
        r = '{value: '0, status: ST_OK, bad_arg: ARG_NONE};
        if (m < 0) begin
            r.status = ST_NEGATIVE; r.bad_arg = ARG_MACH;
        end else if (z < 0) begin
            r.status = ST_NEGATIVE; r.bad_arg = ARG_ZETA;
        end else if (s < 0) begin
            r.status = ST_NEGATIVE; r.bad_arg = ARG_SLOPE;
        end else if (z > ONE_Q) begin
            r.status = ST_ABOVE; r.bad_arg = ARG_ZETA;
        end
        if (r.status != ST_OK) return r;
        if (m > MACH_MAX) m = MACH_MAX;
        if (s > SLOPE_MAX) s = SLOPE_MAX;
        ya = curve_at(0, s);
        yb = blend(0, curve_at(1, s), ONE_Q, curve_at(2, s), z);
        if (m < MACH_LOW) y = ya;
        else if (m < MACH_HIGH) y = blend(MACH_LOW, ya, MACH_HIGH, yb, m);
        else y = yb;
        if (y < 0) y = 0;
        if (y > 16383) y = 16383;
        r.value = y[13:0];
        return r;
    endfunction

    // Queue expectations on each request, compare on each result
    always @(posedge i_clk) begin
        t_chart_res exp_r, got;
        if (!i_rst_n) begin
            chart_q.delete();
            o_errors  <= 0;
            o_seen    <= 0;
            o_pending <= 0;
        end else begin
            if (i_req_valid && i_req_ready)
                chart_q.push_back(chart_predict(i_req_data));
            if (i_res_valid && i_res_ready) begin
                got = i_res_data[17:0];
                o_seen <= o_seen + 1;
                if (chart_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_res_data);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = chart_q.pop_front();
                    if (got !== exp_r || i_res_data[23:18] !== 6'd0) begin
                        $display("%0t: mismatch expected value %0d status %0d arg %0d,",
                                 $time, exp_r.value, exp_r.status, exp_r.bad_arg);
                        $display("    actual value %0d status %0d arg %0d (raw %h)",
                                 got.value, got.status, got.bad_arg, i_res_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= chart_q.size();
        end
    end
endmodule

// File: dv/tb_top.sv
// Testbench top for the chart curve blend interpolator: clock, reset,
// directed and random requests, verdict. Depends on ccbi_pkg, ccbi_checker.
`timescale 1ns / 100ps

module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    int          errors, pending, seen;
    int          idle_cycles = 0;
    bit          timed_out;
    int          sent;

    chart_curve_blend_interpolator dut (.*);

    ccbi_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata),
        .o_errors(errors), .o_pending(pending), .o_seen(seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver stalls: random mode per stretch, sometimes always ready
    initial begin
        int mode, len;
        m_axis_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) > 1);
                endcase
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            timed_out = 1'b1;
            $display("Verification failed");
            $finish;
        end
    end

    // Hold one request until accepted, with an optional gap first
    task automatic send_request(logic [15:0] m, logic [15:0] z, logic [15:0] s, int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s, z, m};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent++;
    endtask

    function automatic logic [15:0] pick_arg(int lim);
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 16383));
            default: return 16'($urandom_range(0, lim));
        endcase
    endfunction

    initial begin
        int burst, gap;
        logic [15:0] m, z, s;
        sent          = 0;
        timed_out     = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: error orders, range extremes, mach bands, clamps
        send_request(16'h8000, 16'h8000, 16'h8000, 0);
        send_request(16'h0000, 16'hFFFF, 16'h8000, 0);
        send_request(16'h0000, 16'h0000, 16'hFFFF, 0);
        send_request(16'h0000, 16'h1001, 16'h0000, 0);
        send_request(16'h0000, 16'h7FFF, 16'h7FFF, 0);
        send_request(16'h0000, 16'h0000, 16'h0000, 0);
        send_request(16'h0000, 16'h1000, 16'h7FFF, 0);
        send_request(16'd4505, 16'h0800, 16'd4000, 0);
        send_request(16'd4506, 16'h0800, 16'd4000, 0);
        send_request(16'd6000, 16'h0800, 16'd4000, 1);
        send_request(16'd8191, 16'h0400, 16'd12553, 0);
        send_request(16'd8192, 16'h0400, 16'd12554, 0);
        send_request(16'd24576, 16'h1000, 16'd12555, 0);
        send_request(16'h7FFF, 16'h0000, 16'd230, 2);
        send_request(16'd24577, 16'h1000, 16'd256, 0);
        send_request(16'd5000, 16'h1000, 16'd296, 0);
        send_request(16'd1000, 16'h0001, 16'd1, 0);
        send_request(16'hAAAA, 16'h5555, 16'h5555, 0);
        send_request(16'h5555, 16'h0AAA, 16'h2AAA, 0);

        // Pause until the pipeline has drained
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        // Random: mostly valid arguments, some errors, bursts with gaps
        while (sent < 620) begin
            burst = $urandom_range(1, 40);
            gap   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
            for (int k = 0; k < burst; k++) begin
                m = pick_arg(28000);
                z = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4096));
                s = pick_arg(13000);
                send_request(m, z, s, k == 0 ? gap : 0);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("Sent %0d requests, checked %0d results: error codes, mach bands,", sent, seen);
        $display("slope and mach clamps and zeta blends, under random stalls.");
        if (errors == 0 && pending == 0 && !timed_out) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// File: chart_curve_blend_interpolator.f
hw/rtl/ccbi_pkg.sv
hw/rtl/chart_curve_blend_interpolator.sv
dv/ccbi_checker.sv
dv/tb_top.sv
